>>> src/ptsa_pkg.sv
// Package: shared types and codes for the priority time-slice arbiter.
package ptsa_pkg;
  localparam logic [2:0] REQ_TICK = 3'd0;
  localparam logic [2:0] REQ_ADD = 3'd1;
  localparam logic [2:0] REQ_REMOVE = 3'd2;
  localparam logic [2:0] REQ_SET_LEVEL = 3'd3;
  localparam logic [2:0] REQ_FRAME = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_ACTIVE = 2'd1;
  localparam logic [1:0] ST_ALREADY = 2'd2;
  localparam logic [1:0] ST_BAD_LEVEL = 2'd3;

  localparam logic [7:0] SLICE_RESET = 8'd10;

  // Per-cell command, broadcast to every cell of a level's queue.
  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_REMOVE,  // drop id, cells behind shift forward
    CMD_APPEND,  // write id into the cell at count
    CMD_ROTATE   // head to back, others shift forward
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ROT,
    S_GRANT,
    S_OUT
  } state_t;
endpackage

>>> src/priority_time_slice_arbiter.sv
// Top level: strict-priority arbiter with round-robin time slices per level.
// Each priority level owns a chain of cells holding client ids in queue order; a rotate
// shifts every cell from its right neighbor, a remove only the matched cell and those
// behind it. Each item passes the four steps (decode and queue update, rotate check,
// grant, result) of the sequencer below; the result is registered, no new item is taken
// while one is in flight or its result is pending, and the next item is taken in the cycle
// after the result transfer. Reset clears counts, flags and time.
module priority_time_slice_arbiter import ptsa_pkg::*; #(
  parameter int MAX_CLIENTS = 16,
  parameter int NUM_LEVELS = 4,
  parameter int TIME_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [15:0] s_tdata,  // req_type[2:0], client_id[6:3], new_level[9:7]
  output logic m_tvalid,
  input  logic m_tready,
  output logic [7:0] m_tdata    // status[1:0], granted[2], holder_id[6:3], holder_valid[7]
);
  localparam int IdW = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
  localparam int CntW = $clog2(MAX_CLIENTS + 1);
  localparam int LvW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;

  state_t state, state_next;
  logic [7:0] slice_seconds;
  logic [TIME_WIDTH-1:0] seconds_now;
  logic [MAX_CLIENTS-1:0] active, started;
  logic [LvW-1:0] clevel [MAX_CLIENTS];
  logic [TIME_WIDTH-1:0] stime [MAX_CLIENTS];
  cmd_t lcmd [NUM_LEVELS];
  logic [IdW-1:0] lid [NUM_LEVELS];
  logic [CntW-1:0] cnt [NUM_LEVELS];
  logic [IdW-1:0] hd [NUM_LEVELS];
  logic [2:0] rtype;
  logic [3:0] rcid;
  logic [2:0] rlvl;
  logic [1:0] status;
  logic granted;
  logic is_frame;
  logic take;
  logic top_ok;
  logic [LvW-1:0] top;
  logic [IdW-1:0] top_head;
  logic [CntW-1:0] top_cnt;
  logic valid_id, act;
  logic [IdW-1:0] id;
  logic [TIME_WIDTH-1:0] elapsed;

  assign s_tready = (state == S_IDLE) && !m_tvalid;
  assign take = s_tvalid && s_tready;
  assign id = IdW'(s_tdata[6:3]);
  assign valid_id = {28'd0, s_tdata[6:3]} < 32'(MAX_CLIENTS);
  assign act = valid_id && active[id];

  genvar g;
  generate
    for (g = 0; g < NUM_LEVELS; g++) begin : g_lvl
      ptsa_level #(.N(MAX_CLIENTS), .IdW(IdW), .CntW(CntW)) u_level (
        .clk(clk), .rst(rst), .cmd(lcmd[g]), .new_id(lid[g]),
        .count(cnt[g]), .head(hd[g])
      );
    end
  endgenerate

  // Pick the highest non-empty level.
  always_comb begin
    top_ok = 1'b0;
    top = '0;
    for (int l = 0; l < NUM_LEVELS; l++) begin
      if (cnt[l] != '0) begin
        top_ok = 1'b1;
        top = LvW'(l);
      end
    end
    top_head = hd[top];
    top_cnt = cnt[top];
  end
  assign elapsed = seconds_now - stime[top_head];

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (take) state_next = S_ROT;
      S_ROT: state_next = S_GRANT;
      S_GRANT: state_next = S_OUT;
      S_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Queue commands for each step.
  always_comb begin
    for (int l = 0; l < NUM_LEVELS; l++) begin
      lcmd[l] = CMD_NONE;
      lid[l] = id;
    end
    if (take && act && s_tdata[2:0] == REQ_REMOVE) begin
      lcmd[clevel[id]] = CMD_REMOVE;
    end else if (take && !act && valid_id && s_tdata[2:0] == REQ_ADD) begin
      lcmd[0] = CMD_APPEND;
    end else if (take && act && s_tdata[2:0] == REQ_SET_LEVEL
                 && {29'd0, s_tdata[9:7]} < 32'(NUM_LEVELS)) begin
      lcmd[clevel[id]] = CMD_REMOVE;
    end else if (state == S_ROT && rtype == REQ_SET_LEVEL && status == ST_OK) begin
      lcmd[LvW'(rlvl)] = CMD_APPEND;
      lid[LvW'(rlvl)] = IdW'(rcid);
    end else if (state == S_ROT && is_frame && top_ok && top_cnt >= CntW'(2)
                 && started[top_head] && elapsed > TIME_WIDTH'(slice_seconds)) begin
      lcmd[top] = CMD_ROTATE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_tvalid <= 1'b0;
      slice_seconds <= SLICE_RESET;
      seconds_now <= '0;
      active <= '0;
      started <= '0;
      is_frame <= 1'b0;
      for (int i = 0; i < MAX_CLIENTS; i++) begin
        clevel[i] <= '0;
        stime[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_we) slice_seconds <= cfg_wdata;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (take) begin
        rtype <= s_tdata[2:0];
        rcid <= s_tdata[6:3];
        rlvl <= s_tdata[9:7];
        granted <= 1'b0;
        is_frame <= 1'b0;
        status <= ST_OK;
        case (s_tdata[2:0])
          REQ_TICK: seconds_now <= seconds_now + 1'b1;
          REQ_ADD: begin
            if (!valid_id) status <= ST_NOT_ACTIVE;
            else if (act) status <= ST_ALREADY;
            else begin
              active[id] <= 1'b1;
              clevel[id] <= '0;
              if (cnt[0] < CntW'(MAX_CLIENTS)) begin
                started[id] <= 1'b0;
                stime[id] <= '0;
              end
            end
          end
          REQ_REMOVE: begin
            if (!act) status <= ST_NOT_ACTIVE;
            else begin
              active[id] <= 1'b0;
              started[id] <= 1'b0;
            end
          end
          REQ_SET_LEVEL: begin
            if (!act) status <= ST_NOT_ACTIVE;
            else if ({29'd0, s_tdata[9:7]} >= 32'(NUM_LEVELS)) status <= ST_BAD_LEVEL;
            else clevel[id] <= LvW'(s_tdata[9:7]);
          end
          REQ_FRAME: begin
            if (!act) status <= ST_NOT_ACTIVE;
            else is_frame <= 1'b1;
          end
          default: status <= ST_OK;
        endcase
      end
      if (state == S_ROT) begin
        if (rtype == REQ_SET_LEVEL && status == ST_OK
            && cnt[LvW'(rlvl)] < CntW'(MAX_CLIENTS)) begin
          started[IdW'(rcid)] <= 1'b0;
          stime[IdW'(rcid)] <= '0;
        end
        if (lcmd[top] == CMD_ROTATE && is_frame) started[top_head] <= 1'b0;
      end
      if (state == S_GRANT && is_frame && top_ok) begin
        if (!started[top_head]) begin
          started[top_head] <= 1'b1;
          stime[top_head] <= seconds_now;
        end
        granted <= (top_head == IdW'(rcid));
      end
      if (state == S_OUT) m_tvalid <= 1'b1;
    end
  end

  assign m_tdata = {top_ok, 4'(top_ok ? top_head : '0), granted, status};
endmodule

>>> src/ptsa_cell.sv
// Queue cell: one slot of a level FIFO, shifts from its right neighbor.
module ptsa_cell import ptsa_pkg::*; #(
  parameter int IdW = 4,
  parameter int PosW = 4
) (
  input  logic clk,
  input  cmd_t cmd,
  input  logic [PosW-1:0] my_pos,
  input  logic [PosW-1:0] sel_pos,
  input  logic [IdW-1:0] new_id,
  input  logic [IdW-1:0] head_id,
  input  logic is_last,
  input  logic [IdW-1:0] right_id,
  input  logic left_match,
  output logic match,
  output logic [IdW-1:0] id
);
  logic [IdW-1:0] id_next;
  assign match = left_match || (id == new_id);
  always_comb begin
    id_next = id;
    case (cmd)
      CMD_REMOVE: if (left_match || (id == new_id)) id_next = right_id;
      CMD_APPEND: if (my_pos == sel_pos) id_next = new_id;
      CMD_ROTATE: id_next = is_last ? head_id : right_id;
      default: id_next = id;
    endcase
  end
  always_ff @(posedge clk) begin
    id <= id_next;
  end
endmodule

>>> src/ptsa_level.sv
// Level queue: a chain of cells plus its fill count.
module ptsa_level import ptsa_pkg::*; #(
  parameter int N = 16,
  parameter int IdW = 4,
  parameter int CntW = 5
) (
  input  logic clk,
  input  logic rst,
  input  cmd_t cmd,
  input  logic [IdW-1:0] new_id,
  output logic [CntW-1:0] count,
  output logic [IdW-1:0] head
);
  localparam int PosW = CntW;
  logic [IdW-1:0] ids [N];
  logic [N:0] mt;
  logic [IdW-1:0] rid [N];
  logic found;
  assign mt[0] = 1'b0;
  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      logic [PosW-1:0] mp;
      logic last;
      assign mp = PosW'(g);
      assign last = (PosW'(g + 1) == count);
      assign rid[g] = (g == N - 1) ? ids[g] : ids[(g + 1) % N];
      ptsa_cell #(.IdW(IdW), .PosW(PosW)) u_cell (
        .clk(clk), .cmd(cmd), .my_pos(mp), .sel_pos(count), .new_id(new_id),
        .head_id(ids[0]), .is_last(last), .right_id(rid[g]),
        .left_match(mt[g] && (mp < count)), .match(mt[g+1]), .id(ids[g])
      );
    end
  endgenerate
  // Match only counts within the filled part of the queue.
  always_comb begin
    found = 1'b0;
    for (int i = 0; i < N; i++) begin
      if (PosW'(i) < count && ids[i] == new_id) found = 1'b1;
    end
  end
  assign head = ids[0];
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (cmd)
        CMD_REMOVE: if (found) count <= count - 1'b1;
        CMD_APPEND: if (count < CntW'(N)) count <= count + 1'b1;
        default: count <= count;
      endcase
    end
  end
endmodule

>>> src/ptsa_checker.sv
// Checker: port-level properties of the arbiter, bound to the top level.
module ptsa_checker (
  input logic clk,
  input logic rst,
  input logic s_tready,
  input logic m_tvalid,
  input logic m_tready,
  input logic [7:0] m_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("input taken with result pending");
  a_grant_holder: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2] |-> m_tdata[7]) else $error("grant without holder");
  a_grant_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2] |-> m_tdata[1:0] == 2'd0) else $error("grant with error");
endmodule

bind priority_time_slice_arbiter ptsa_checker u_ptsa_checker (
  .clk(clk), .rst(rst), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

>>> bench/priority_time_slice_arbiter_test.sv
// Testbench for the priority time-slice arbiter: directed and random traffic, predictor-checked.
`timescale 1ns / 1ps
module priority_time_slice_arbiter_test;
  import ptsa_pkg::*;

  localparam int NCLI = 16;
  localparam int NLVL = 4;
  localparam int WATCHDOG_LIMIT = 2000;

  // Fields listed from the highest bit down, so req_type lands in the lowest bits.
  typedef struct packed {
    logic [2:0] new_level;
    logic [3:0] client_id;
    logic [2:0] req_type;
  } request_t;

  // Fields listed from the highest bit down, so status lands in the lowest bits.
  typedef struct packed {
    logic       holder_valid;
    logic [3:0] holder_id;
    logic       granted;
    logic [1:0] status;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [15:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [7:0] m_tdata;

  priority_time_slice_arbiter dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Predictor state, a private copy of the arbiter's queues and timers.
  logic [3:0]  lvl_fifo [NLVL][NCLI];
  int          lvl_count [NLVL];
  logic        is_active [NCLI];
  logic [2:0]  cli_level [NCLI];
  logic        slice_on [NCLI];
  logic [31:0] slice_t0 [NCLI];
  logic [31:0] clock_secs;
  logic [7:0]  slice_len;

  request_t pending_reqs[$];
  answer_t  expected_answers[$];
  int errors = 0;
  int issued = 0;
  int checked = 0;
  int stall_in = 0;
  int stall_out = 0;
  int idle_cycles = 0;
  bit timed_out = 0;

  task automatic report(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic void reset_model();
    for (int l = 0; l < NLVL; l++) lvl_count[l] = 0;
    for (int c = 0; c < NCLI; c++) begin
      is_active[c] = 0; cli_level[c] = 0; slice_on[c] = 0; slice_t0[c] = 0;
    end
    clock_secs = 0;
    slice_len = SLICE_RESET;
  endfunction

  function automatic void fifo_drop(int l, logic [3:0] id);
    int pos;
    pos = lvl_count[l];
    for (int i = 0; i < lvl_count[l]; i++)
      if (lvl_fifo[l][i] == id && pos == lvl_count[l]) pos = i;
    if (pos >= lvl_count[l]) return;
    for (int i = pos; i + 1 < lvl_count[l]; i++) lvl_fifo[l][i] = lvl_fifo[l][i+1];
    lvl_count[l]--;
  endfunction

  function automatic void fifo_push(int l, logic [3:0] id);
    if (lvl_count[l] >= NCLI) return;
    lvl_fifo[l][lvl_count[l]] = id;
    lvl_count[l]++;
    slice_on[id] = 0;
    slice_t0[id] = 0;
  endfunction

  function automatic int highest_level();
    for (int l = NLVL - 1; l >= 0; l--)
      if (lvl_count[l] != 0) return l;
    return -1;
  endfunction

  // Rotate an expired head to the back, then start the slice of whoever leads.
  function automatic void pick_holder();
    int l;
    int n;
    logic [3:0] head;
    l = highest_level();
    if (l < 0) return;
    n = lvl_count[l];
    head = lvl_fifo[l][0];
    if (n >= 2 && slice_on[head] && (clock_secs - slice_t0[head]) > {24'd0, slice_len}) begin
      for (int i = 0; i + 1 < n; i++) lvl_fifo[l][i] = lvl_fifo[l][i+1];
      lvl_fifo[l][n-1] = head;
      slice_on[head] = 0;
      head = lvl_fifo[l][0];
    end
    if (!slice_on[head]) begin
      slice_on[head] = 1;
      slice_t0[head] = clock_secs;
    end
  endfunction

  function automatic answer_t arbitrate_request(request_t r);
    answer_t a;
    int top;
    logic [3:0] id;
    id = r.client_id;
    a = '0;
    case (r.req_type)
      REQ_TICK: clock_secs = clock_secs + 1;
      REQ_ADD: begin
        if (is_active[id]) a.status = ST_ALREADY;
        else begin
          is_active[id] = 1; cli_level[id] = 0; fifo_push(0, id);
        end
      end
      REQ_REMOVE: begin
        if (!is_active[id]) a.status = ST_NOT_ACTIVE;
        else begin
          fifo_drop(cli_level[id], id); is_active[id] = 0; slice_on[id] = 0;
        end
      end
      REQ_SET_LEVEL: begin
        if (!is_active[id]) a.status = ST_NOT_ACTIVE;
        else if (r.new_level >= NLVL) a.status = ST_BAD_LEVEL;
        else begin
          fifo_drop(cli_level[id], id);
          cli_level[id] = r.new_level;
          fifo_push(r.new_level, id);
        end
      end
      REQ_FRAME: begin
        if (!is_active[id]) a.status = ST_NOT_ACTIVE;
        else begin
          pick_holder();
          top = highest_level();
          if (top >= 0 && lvl_fifo[top][0] == id) a.granted = 1;
        end
      end
      default: ;
    endcase
    top = highest_level();
    if (top >= 0) begin
      a.holder_id = lvl_fifo[top][0];
      a.holder_valid = 1;
    end
    return a;
  endfunction

  function automatic void queue_req(logic [2:0] t, logic [3:0] id, logic [2:0] lv);
    request_t r;
    r.req_type = t; r.client_id = id; r.new_level = lv;
    pending_reqs.push_back(r);
  endfunction

  // Random traffic: mostly frames and ticks so slices expire, with churn of clients.
  function automatic void queue_random(int count);
    int pick;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) queue_req(REQ_TICK, 4'($urandom), 3'($urandom));
      else if (pick < 42) queue_req(REQ_ADD, 4'($urandom), 3'($urandom));
      else if (pick < 50) queue_req(REQ_REMOVE, 4'($urandom), 3'($urandom));
      else if (pick < 62) queue_req(REQ_SET_LEVEL, 4'($urandom),
                                    3'($urandom_range(0, 4) == 0 ?
                                       $urandom_range(4, 7) : $urandom_range(0, 3)));
      else if (pick < 96) queue_req(REQ_FRAME, 4'($urandom), 3'($urandom));
      else queue_req(3'($urandom_range(5, 7)), 4'($urandom), 3'($urandom));
    end
  endfunction

  // Driver: present one pending item per transfer, with a random gap after each.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !s_tready) begin
      // hold
    end else begin
      if (s_tvalid) begin
        expected_answers.push_back(arbitrate_request(request_t'(s_tdata[9:0])));
      end
      if (stall_in > 0) begin
        stall_in--;
        s_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        s_tdata <= {6'd0, pending_reqs.pop_front()};
        s_tvalid <= 1'b1;
        issued++;
        stall_in = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) stall_in = 0;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: compare each result transfer with the oldest expectation; throttle tready.
  always @(posedge clk) begin
    answer_t got;
    answer_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = answer_t'(m_tdata);
        checked++;
        if (expected_answers.size() == 0) begin
          report($sformatf("unexpected result %h", m_tdata));
        end else begin
          want = expected_answers.pop_front();
          if (got.status !== want.status)
            report($sformatf("status %0d, want %0d", got.status, want.status));
          if (got.granted !== want.granted)
            report($sformatf("granted %0d, want %0d", got.granted, want.granted));
          if (got.holder_id !== want.holder_id)
            report($sformatf("holder_id %0d, want %0d", got.holder_id, want.holder_id));
          if (got.holder_valid !== want.holder_valid)
            report($sformatf("holder_valid %0d, want %0d", got.holder_valid,
                             want.holder_valid));
        end
        stall_out = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) stall_out = 0;
      end
      if (stall_out > 0) begin
        stall_out--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: count cycles with no transfer on either side.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) timed_out = 1;
  end

  // Every item handed to the driver must come back as a result transfer.
  task automatic wait_drained();
    while ((pending_reqs.size() > 0 || issued != checked) && !timed_out)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_slice(logic [7:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    slice_len = v;
  endtask

  initial begin
    logic [7:0] slice_settings [4];
    reset_model();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty-table requests, adds incl. double add, levels, invalid level,
    // same-level move, unknown types, remove, ticks until a slice rotates.
    queue_req(REQ_FRAME, 4'd0, 3'd0);
    queue_req(REQ_REMOVE, 4'd15, 3'd0);
    queue_req(REQ_ADD, 4'd0, 3'd0);
    queue_req(REQ_ADD, 4'd15, 3'd7);
    queue_req(REQ_ADD, 4'd15, 3'd0);
    queue_req(REQ_ADD, 4'd5, 3'd0);
    queue_req(REQ_FRAME, 4'd0, 3'd0);
    queue_req(REQ_SET_LEVEL, 4'd15, 3'd4);
    queue_req(REQ_SET_LEVEL, 4'd15, 3'd7);
    queue_req(REQ_SET_LEVEL, 4'd15, 3'd3);
    queue_req(REQ_SET_LEVEL, 4'd5, 3'd3);
    queue_req(REQ_SET_LEVEL, 4'd15, 3'd3);
    queue_req(REQ_SET_LEVEL, 4'd9, 3'd1);
    queue_req(REQ_FRAME, 4'd5, 3'd0);
    for (int i = 0; i < 11; i++) queue_req(REQ_TICK, 4'd0, 3'd0);
    queue_req(REQ_FRAME, 4'd15, 3'd0);
    queue_req(3'd5, 4'd3, 3'd2);
    queue_req(3'd7, 4'd15, 3'd7);
    queue_req(REQ_REMOVE, 4'd5, 3'd0);
    queue_req(REQ_FRAME, 4'd5, 3'd0);
    wait_drained();

    slice_settings[0] = 8'd0;
    slice_settings[1] = 8'd255;
    slice_settings[2] = 8'd3;
    slice_settings[3] = 8'd1;
    for (int p = 0; p < 4 && !timed_out; p++) begin
      write_slice(slice_settings[p]);
      queue_random(p == 1 ? 120 : 190);
      wait_drained();
    end

    if (timed_out) begin
      $display("Test completed with failures");
    end else if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
